// ----- rtl/core/sorted_record_table_core_macros.svh -----
// Assertion macros for the sorted record table core.
`ifndef SORTED_RECORD_TABLE_CORE_MACROS_SVH
`define SORTED_RECORD_TABLE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define SRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_record_table_core: check failed");

// Next-cycle implication, clocked on clk, quiet during reset.
`define SRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_record_table_core: check failed");

`endif

// ----- rtl/core/srt_pkg.sv -----
// Types and constants shared by the sorted record table core.
`default_nettype none

package srt_pkg;

  localparam int DEPTH      = 64;
  localparam int AGE_BITS   = 8;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 7;
  localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ID_W       = 16;
  localparam int CLS_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 6;
  localparam int ENTRIES_W  = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // request codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // register word address (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [CLS_W-1:0]    cls;
    logic [AGE_BITS-1:0] age;
  } rec_t;

endpackage

`default_nettype wire

// ----- rtl/core/sorted_record_table_core.sv -----
// Sorted record table: records kept in one RAM, ordered by class then age.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid / in_ready     | func, rec_id, rec_class, rec_age
//   out     | output    | out_valid / out_ready   | status, position, entries
//   cfg     | input     | psel/penable/pwrite     | paddr, pwdata, prdata (capacity)
//
// One request at a time; in_ready is high only while the core is idle.
// Insert: walks down from the top record, moving each one up a slot; empty table: written directly; full: no scan.
// Delete: scans every record held; rejected or empty: no scan.
// Scans are paced by the single RAM read port: one record moved per cycle.
// A result waits in the output register; a stalled out_ready holds the core in its
// final state until the pending result is taken. Synchronous active-low reset.
`default_nettype none

module sorted_record_table_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic                             in_func,
  input  wire logic signed [srt_pkg::ID_W-1:0]  in_rec_id,
  input  wire logic [srt_pkg::CLS_W-1:0]        in_rec_class,
  input  wire logic [7:0]                       in_rec_age,
  // result channel
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [srt_pkg::STATUS_W-1:0]     out_status,
  output      logic [srt_pkg::POS_W-1:0]        out_position,
  output      logic [srt_pkg::ENTRIES_W-1:0]    out_entries,
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [srt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [srt_pkg::CFG_DATA_W-1:0]   pwdata,
  output      logic [srt_pkg::CFG_DATA_W-1:0]   prdata,
  output      logic                             pready
);

  `include "sorted_record_table_core_macros.svh"

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INS_SCAN = 3'd1;
  localparam logic [2:0] ST_INS_PUT  = 3'd2;
  localparam logic [2:0] ST_DEL_SCAN = 3'd3;
  localparam logic [2:0] ST_FINISH   = 3'd4;

  localparam int ADDR_W = srt_pkg::ADDR_W;
  localparam int CNT_W  = srt_pkg::CNT_W;
  localparam int CMP_W  = srt_pkg::CMP_W;

  // record RAM
  srt_pkg::rec_t mem [srt_pkg::DEPTH];
  srt_pkg::rec_t rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  srt_pkg::rec_t     wr_data;

  logic [2:0]                   state_r, state_nxt;
  logic [ADDR_W-1:0]            idx_r, idx_nxt;
  logic [ADDR_W-1:0]            pos_r, pos_nxt;
  logic [srt_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                         found_r, found_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  srt_pkg::rec_t                req_r, req_nxt;
  logic [srt_pkg::CAP_W-1:0]    cap_r;

  logic                           out_valid_r;
  logic [srt_pkg::STATUS_W-1:0]   out_status_r;
  logic [srt_pkg::POS_W-1:0]      out_position_r;
  logic [srt_pkg::ENTRIES_W-1:0]  out_entries_r;
  logic                           out_load;

  srt_pkg::rec_t new_rec;
  logic          ins_full;
  logic          del_hit;
  logic          del_last;

  // stored record sorts before (or ties with) the incoming one
  function automatic logic goes_before(input srt_pkg::rec_t r, input srt_pkg::rec_t n);
    goes_before = (r.cls < n.cls) || ((r.cls == n.cls) && (r.age >= n.age));
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign new_rec.id  = in_rec_id;
  assign new_rec.cls = in_rec_class;
  assign new_rec.age = srt_pkg::AGE_BITS'(in_rec_age);

  assign ins_full = (CMP_W'(count_r) >= CMP_W'(cap_r)) ||
                    (count_r >= CNT_W'(srt_pkg::DEPTH));
  assign del_hit  = (rd_data_r.id == req_r.id);
  assign del_last = (CNT_W'(idx_r) == (count_r - 1'b1));

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    count_nxt  = count_r;
    req_nxt    = req_r;
    rd_addr    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_data_r;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt    = new_rec;
          status_nxt = srt_pkg::STATUS_OK;
          pos_nxt    = '0;
          found_nxt  = 1'b0;
          if (in_func == srt_pkg::FUNC_INSERT) begin
            if (ins_full) begin
              status_nxt = srt_pkg::STATUS_FULL;
              state_nxt  = ST_FINISH;
            end else if (count_r == '0) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_data   = new_rec;
              count_nxt = count_r + 1'b1;
              state_nxt = ST_FINISH;
            end else begin
              // walk down from the top record, moving each one up a slot
              rd_addr   = ADDR_W'(count_r - 1'b1);
              idx_nxt   = ADDR_W'(count_r - 1'b1);
              state_nxt = ST_INS_SCAN;
            end
          end else begin
            if (in_rec_id[srt_pkg::ID_W-1] || (count_r == '0)) begin
              status_nxt = srt_pkg::STATUS_NOT_FOUND;
              state_nxt  = ST_FINISH;
            end else begin
              rd_addr   = '0;
              idx_nxt   = '0;
              state_nxt = ST_DEL_SCAN;
            end
          end
        end
      end
      ST_INS_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(idx_r + 1'b1);
        if (goes_before(rd_data_r, req_r)) begin
          wr_data   = req_r;
          pos_nxt   = ADDR_W'(idx_r + 1'b1);
          count_nxt = count_r + 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          wr_data = rd_data_r;
          if (idx_r == '0) begin
            state_nxt = ST_INS_PUT;
          end else begin
            rd_addr = idx_r - 1'b1;
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      ST_INS_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = req_r;
        pos_nxt   = '0;
        count_nxt = count_r + 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_DEL_SCAN: begin
        // after the match every record moves down one slot
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = idx_r - 1'b1;
          wr_data = rd_data_r;
        end else if (del_hit) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
        end
        if (del_last) begin
          if (found_r || del_hit) begin
            count_nxt  = count_r - 1'b1;
            status_nxt = srt_pkg::STATUS_OK;
          end else begin
            status_nxt = srt_pkg::STATUS_NOT_FOUND;
            pos_nxt    = '0;
          end
          state_nxt = ST_FINISH;
        end else begin
          rd_addr = ADDR_W'(idx_r + 1'b1);
          idx_nxt = ADDR_W'(idx_r + 1'b1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    req_r    <= req_nxt;
    if (out_load) begin
      out_status_r   <= status_r;
      out_position_r <= srt_pkg::POS_W'(pos_r);
      out_entries_r  <= srt_pkg::ENTRIES_W'(count_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_entries  = out_entries_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= srt_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == srt_pkg::REG_CAPACITY)) begin
      cap_r <= pwdata[srt_pkg::CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == srt_pkg::REG_CAPACITY) ?
                  srt_pkg::CFG_DATA_W'(cap_r) : '0;

  `SRT_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_r != ST_IDLE)
  `SRT_ASSERT_NXT(a_finish_loads_out, out_load, out_valid_r && (state_r == ST_IDLE))
  `SRT_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(srt_pkg::DEPTH))
  `SRT_ASSERT_IMP(a_del_idx_in_range, state_r == ST_DEL_SCAN, CNT_W'(idx_r) < count_r)

endmodule

`default_nettype wire
